// ----- sv/sipq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sipq_pkg: shared types and constants of the sorted insertion queue
// Request and result beats, the stored entry and the per-cell operation.
// ----------------------------------------------------------------------------
package sipq_pkg;

    localparam int KEY_W = 8;
    localparam int TAG_W = 2;
    localparam int OCC_W = 5;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] in_key;
        logic [TAG_W-1:0] in_tag;
    } sipq_req_t;

    typedef struct packed {
        logic             out_valid;
        logic [KEY_W-1:0] out_key;
        logic [TAG_W-1:0] out_tag;
        logic             rejected;
        logic [OCC_W-1:0] occupancy;
    } sipq_rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } sipq_entry_t;

    // Chain-wide operation for the current cycle; at most one bit is set.
    typedef struct packed {
        logic ins;
        logic rem;
    } sipq_op_t;

endpackage : sipq_pkg
`default_nettype wire

// ----- sv/sipq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sipq_cell: one slot of the sorted chain
// Holds one entry, tells its right neighbor whether the new key lands
// behind it, and on an update takes the new entry or a neighbor's entry.
// ----------------------------------------------------------------------------
module sipq_cell
    import sipq_pkg::*;
(
    input  wire         clk,
    input  wire         occupied,
    input  sipq_op_t    op,
    input  sipq_entry_t new_entry,
    input  sipq_entry_t left_entry,
    input  sipq_entry_t right_entry,
    input  wire         left_behind,
    output sipq_entry_t entry,
    output logic        behind
);

    sipq_entry_t entry_reg;
    sipq_entry_t entry_next;

    // Equal keys stay ahead of the new entry.
    assign behind = occupied && (entry_reg.key >= new_entry.key);
    assign entry  = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (op.ins && !behind)
        begin
            // First cell past the insertion point takes the new entry,
            // every later one shifts toward the tail.
            entry_next = left_behind ? new_entry : left_entry;
        end
        else if (op.rem)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule : sipq_cell
`default_nettype wire

// ----- sv/sorted_insert_priority_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A result beat is registered and appears in the cycle after its request beat is accepted.
// The queue takes one request per cycle while the result side is not stalled;
// every cell of the chain updates in the same cycle.
// Reset clears the fill count and the result valid flag; cell contents are
// left as they are and only slots below the fill count are ever read.
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue: priority queue on a chain of sorted cells
// Inserts place an entry behind all entries of equal or higher key, removes
// pop the head. Each request yields one result with the new occupancy.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue
    import sipq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire       clk,
    input  wire       rst_n,
    input  wire       req_valid,
    output logic      req_stall,
    input  sipq_req_t req,
    output logic      rsp_valid,
    input  wire       rsp_stall,
    output sipq_rsp_t rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    sipq_rsp_t     rsp_reg;
    sipq_rsp_t     rsp_next;

    logic          accept;
    logic          full;
    logic          empty;
    sipq_op_t      op;
    sipq_entry_t   new_entry;
    sipq_entry_t   cell_entry [DEPTH];
    logic          cell_behind [DEPTH];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);

    assign op.ins = accept && (req.kind == KIND_INSERT) && !full;
    assign op.rem = accept && (req.kind == KIND_REMOVE) && !empty;

    assign new_entry.key = req.in_key;
    assign new_entry.tag = req.in_tag;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);

        sipq_entry_t left_entry;
        sipq_entry_t right_entry;
        logic        left_behind;

        if (i == 0)
        begin : g_head
            assign left_entry  = new_entry;
            assign left_behind = 1'b1;
        end
        else
        begin : g_body
            assign left_entry  = cell_entry[i-1];
            assign left_behind = cell_behind[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_entry = new_entry;
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        sipq_cell u_cell (
            .clk         (clk),
            .occupied    (IDX < count_reg),
            .op          (op),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .left_behind (left_behind),
            .entry       (cell_entry[i]),
            .behind      (cell_behind[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (op.ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (op.rem)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        rsp_next.out_valid = op.rem;
        rsp_next.out_key   = op.rem ? cell_entry[0].key : '0;
        rsp_next.out_tag   = op.rem ? cell_entry[0].tag : '0;
        rsp_next.rejected  = (req.kind == KIND_INSERT) && full;
        rsp_next.occupancy = OCC_W'(count_next);
    end

    // Hold the result beat while stalled, drop it once taken.
    assign rsp_valid_next = accept ? 1'b1 : (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        op.ins |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the queue");

    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.kind == KIND_INSERT && full) |=> $stable(count_reg))
        else $error("refused insert changed the queue");

    a_reject_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.rejected) |-> !rsp.out_valid)
        else $error("refused insert returned an entry");

    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CW'(2)) |-> cell_entry[0].key >= cell_entry[1].key)
        else $error("head entry out of order");

endmodule : sorted_insert_priority_queue
`default_nettype wire
